@@ design/bond_table_lru_assert.svh @@
// ----------------------------------------------------------------------------
// bond table assertion macros
// shared concurrent assertion forms, synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef BOND_TABLE_LRU_ASSERT_SVH
`define BOND_TABLE_LRU_ASSERT_SVH

// same-cycle implication
`define BTL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bond table check failed");

// next-cycle implication
`define BTL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bond table check failed");

`endif

@@ design/btl_pkg.sv @@
// ----------------------------------------------------------------------------
// btl_pkg
// shared types and constants of the bond table
// ----------------------------------------------------------------------------
`default_nettype none

package btl_pkg;

  localparam int SLOTS  = 4;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int ACT_W   = 3;
  localparam int ATYPE_W = 4;
  localparam int ADDR_W  = 48;
  localparam int KEY_W   = 64;
  localparam int EDIV_W  = 16;
  localparam int RAND_W  = 64;
  localparam int KSIZE_W = 5;
  localparam int SEC_W   = 3;
  localparam int AGE_W   = 32;
  localparam int RSLOT_W = 2;
  localparam int COUNT_W = 3;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD     = 3'd0,
    ACT_REMOVE  = 3'd1,
    ACT_INFO    = 3'd2,
    ACT_ENC_SET = 3'd3,
    ACT_ENC_GET = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_READ,
    S_MODIFY
  } state_t;

  // one stored table entry
  typedef struct packed {
    logic [ATYPE_W-1:0] atype;
    logic [ADDR_W-1:0]  addr;
    logic [KEY_W-1:0]   irk_high;
    logic [KEY_W-1:0]   irk_low;
    logic [KEY_W-1:0]   ltk_high;
    logic [KEY_W-1:0]   ltk_low;
    logic [RAND_W-1:0]  rnd;
    logic [EDIV_W-1:0]  ediv;
    logic [KSIZE_W-1:0] key_len;
    logic [SEC_W-1:0]   security;
    logic [AGE_W-1:0]   age;
  } entry_t;

  // captured request
  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [2:0]         slot;
    logic [ATYPE_W-1:0] address_type;
    logic [ADDR_W-1:0]  device_address;
    logic [KEY_W-1:0]   key_high;
    logic [KEY_W-1:0]   key_low;
    logic               key_present;
    logic [EDIV_W-1:0]  ediv_value;
    logic [RAND_W-1:0]  random_value;
    logic               random_present;
    logic [KSIZE_W-1:0] key_len;
    logic [SEC_W-1:0]   security_flags;
  } req_t;

  // result transaction
  typedef struct packed {
    logic [RSLOT_W-1:0] result_slot;
    logic               entry_valid;
    logic [ATYPE_W-1:0] out_address_type;
    logic [ADDR_W-1:0]  out_address;
    logic [KEY_W-1:0]   out_key_high;
    logic [KEY_W-1:0]   out_key_low;
    logic [EDIV_W-1:0]  out_ediv;
    logic [RAND_W-1:0]  out_random;
    logic [KSIZE_W-1:0] out_key_len;
    logic [SEC_W-1:0]   out_security;
    logic [COUNT_W-1:0] bond_count;
  } res_t;

endpackage

`default_nettype wire

@@ design/btl_in_if.sv @@
// ----------------------------------------------------------------------------
// btl_in_if
// request channel of the bond table: valid/ready plus request fields
// ----------------------------------------------------------------------------
`default_nettype none

interface btl_in_if;
  logic                          valid;
  logic                          ready;
  logic [btl_pkg::ACT_W-1:0]     action;
  logic [2:0]                    slot;
  logic [btl_pkg::ATYPE_W-1:0]   address_type;
  logic [btl_pkg::ADDR_W-1:0]    device_address;
  logic [btl_pkg::KEY_W-1:0]     key_high;
  logic [btl_pkg::KEY_W-1:0]     key_low;
  logic                          key_present;
  logic [btl_pkg::EDIV_W-1:0]    ediv_value;
  logic [btl_pkg::RAND_W-1:0]    random_value;
  logic                          random_present;
  logic [btl_pkg::KSIZE_W-1:0]   key_len;
  logic [btl_pkg::SEC_W-1:0]     security_flags;

  modport source (
    output valid, action, slot, address_type, device_address, key_high, key_low,
           key_present, ediv_value, random_value, random_present, key_len,
           security_flags,
    input  ready
  );

  modport sink (
    input  valid, action, slot, address_type, device_address, key_high, key_low,
           key_present, ediv_value, random_value, random_present, key_len,
           security_flags,
    output ready
  );
endinterface

`default_nettype wire

@@ design/btl_out_if.sv @@
// ----------------------------------------------------------------------------
// btl_out_if
// result channel of the bond table: valid/ready plus result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface btl_out_if;
  logic                          valid;
  logic                          ready;
  logic [btl_pkg::RSLOT_W-1:0]   result_slot;
  logic                          entry_valid;
  logic [btl_pkg::ATYPE_W-1:0]   out_address_type;
  logic [btl_pkg::ADDR_W-1:0]    out_address;
  logic [btl_pkg::KEY_W-1:0]     out_key_high;
  logic [btl_pkg::KEY_W-1:0]     out_key_low;
  logic [btl_pkg::EDIV_W-1:0]    out_ediv;
  logic [btl_pkg::RAND_W-1:0]    out_random;
  logic [btl_pkg::KSIZE_W-1:0]   out_key_len;
  logic [btl_pkg::SEC_W-1:0]     out_security;
  logic [btl_pkg::COUNT_W-1:0]   bond_count;

  modport source (
    output valid, result_slot, entry_valid, out_address_type, out_address,
           out_key_high, out_key_low, out_ediv, out_random, out_key_len,
           out_security, bond_count,
    input  ready
  );

  modport sink (
    input  valid, result_slot, entry_valid, out_address_type, out_address,
           out_key_high, out_key_low, out_ediv, out_random, out_key_len,
           out_security, bond_count,
    output ready
  );
endinterface

`default_nettype wire

@@ design/bond_table_lru.sv @@
// ----------------------------------------------------------------------------
// bond_table_lru
// table of paired-device entries with least-recently-added replacement
// ----------------------------------------------------------------------------
// usage
//   in_ch  : request transactions (add, remove, info, encryption set/get),
//            taken when valid and ready are both high
//   out_ch : exactly one result transaction per request, same order
//   one request is worked at a time; in_ch.ready is high only while idle
//   steps: add does one read per slot through the single memory read port,
//   then one re-read of the chosen entry, and its write-back as the result
//   register is loaded; every other action reads, then modifies; remove and
//   encryption set write back in range, as the result register is loaded
//   a new request is taken only after the result of the last one is loaded
//   stall: a result waits in the output register; the next request is still
//   taken and worked up to write-back, then holds until the register frees
//   reset: valid marks, age counter and control clear at once; entry memory
//   is not swept, an entry is only ever observed after an add rewrote it
// ----------------------------------------------------------------------------
`default_nettype none

`include "bond_table_lru_assert.svh"

module bond_table_lru (
  input  wire logic clk,
  input  wire logic rst_n,
  btl_in_if.sink    in_ch,
  btl_out_if.source out_ch
);

  localparam int SW = btl_pkg::SLOT_W;

  // entry store: one read port with registered data, one write port
  btl_pkg::entry_t mem [btl_pkg::SLOTS];
  btl_pkg::entry_t rd_data_r;
  btl_pkg::entry_t wr_ent;
  logic            mem_re;
  logic            mem_we;
  logic [SW-1:0]   rd_idx;

  // control
  btl_pkg::state_t state_r, state_nxt;
  btl_pkg::req_t   req_r;
  logic [btl_pkg::SLOTS-1:0] valid_r, valid_nxt;
  logic [btl_pkg::AGE_W-1:0] seq_r;
  logic [SW-1:0]   scan_idx_r;
  logic [SW-1:0]   chk_idx_r;
  logic            chk_vld_r;
  logic [SW-1:0]   tgt_r, tgt;

  // scan results
  logic            hit_found_r, empty_found_r;
  logic [SW-1:0]   hit_idx_r, empty_idx_r, lru_idx_r;
  logic [btl_pkg::AGE_W-1:0] lru_age_r;

  // output register
  btl_pkg::res_t   res_r, res_nxt;
  logic            out_valid_r;

  logic in_fire, advance, in_range, scan_last;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign advance   = (state_r == btl_pkg::S_MODIFY) && (!out_valid_r || out_ch.ready);
  assign in_range  = int'(req_r.slot) < btl_pkg::SLOTS;
  assign scan_last = scan_idx_r == SW'(btl_pkg::SLOTS - 1);

  // target slot: scan outcome for add, request slot otherwise
  always_comb begin
    if (req_r.action == btl_pkg::ACT_ADD) begin
      priority if (hit_found_r) begin
        tgt = hit_idx_r;
      end else if (empty_found_r) begin
        tgt = empty_idx_r;
      end else begin
        tgt = lru_idx_r;
      end
    end else begin
      tgt = SW'(req_r.slot);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btl_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_ch.action == btl_pkg::ACT_ADD) ? btl_pkg::S_SCAN
                                                         : btl_pkg::S_READ;
        end
      end
      btl_pkg::S_SCAN: begin
        if (scan_last) begin
          state_nxt = btl_pkg::S_LAST;
        end
      end
      btl_pkg::S_LAST:   state_nxt = btl_pkg::S_READ;
      btl_pkg::S_READ:   state_nxt = btl_pkg::S_MODIFY;
      btl_pkg::S_MODIFY: begin
        if (advance) begin
          state_nxt = btl_pkg::S_IDLE;
        end
      end
      default: state_nxt = btl_pkg::S_IDLE;
    endcase
  end

  // state outputs: handshake and memory read port
  always_comb begin
    in_ch.ready = 1'b0;
    mem_re      = 1'b0;
    rd_idx      = tgt;
    unique case (state_r)
      btl_pkg::S_IDLE: in_ch.ready = 1'b1;
      btl_pkg::S_SCAN: begin
        mem_re = 1'b1;
        rd_idx = scan_idx_r;
      end
      btl_pkg::S_READ: mem_re = 1'b1;
      btl_pkg::S_LAST, btl_pkg::S_MODIFY: ;
      default: ;
    endcase
  end

  // modify the read entry, build the result
  always_comb begin
    wr_ent    = rd_data_r;
    mem_we    = 1'b0;
    valid_nxt = valid_r;
    res_nxt   = '0;
    res_nxt.result_slot = btl_pkg::RSLOT_W'(req_r.slot);
    unique case (req_r.action)
      btl_pkg::ACT_ADD: begin
        if (!hit_found_r) begin
          // new or evicted entry starts clean
          wr_ent       = '0;
          wr_ent.atype = req_r.address_type;
          wr_ent.addr  = req_r.device_address;
        end
        wr_ent.age = seq_r;
        if (req_r.key_present) begin
          wr_ent.irk_high = req_r.key_high;
          wr_ent.irk_low  = req_r.key_low;
        end
        mem_we              = advance;
        valid_nxt[tgt_r]    = 1'b1;
        res_nxt.result_slot = btl_pkg::RSLOT_W'(tgt_r);
        res_nxt.entry_valid = 1'b1;
      end
      btl_pkg::ACT_REMOVE: begin
        if (in_range) begin
          wr_ent           = '0;
          mem_we           = advance;
          valid_nxt[tgt_r] = 1'b0;
        end
      end
      btl_pkg::ACT_INFO: begin
        if (in_range && valid_r[tgt_r]) begin
          res_nxt.entry_valid      = 1'b1;
          res_nxt.out_address_type = rd_data_r.atype;
          res_nxt.out_address      = rd_data_r.addr;
          res_nxt.out_key_high     = rd_data_r.irk_high;
          res_nxt.out_key_low      = rd_data_r.irk_low;
        end
      end
      btl_pkg::ACT_ENC_SET: begin
        if (in_range) begin
          wr_ent.ediv     = req_r.ediv_value;
          wr_ent.key_len  = req_r.key_len;
          wr_ent.security = req_r.security_flags;
          if (req_r.random_present) begin
            wr_ent.rnd = req_r.random_value;
          end
          if (req_r.key_present) begin
            wr_ent.ltk_high = req_r.key_high;
            wr_ent.ltk_low  = req_r.key_low;
          end
          mem_we              = advance;
          res_nxt.entry_valid = valid_r[tgt_r];
        end
      end
      btl_pkg::ACT_ENC_GET: begin
        if (in_range && valid_r[tgt_r]) begin
          res_nxt.entry_valid  = 1'b1;
          res_nxt.out_key_high = rd_data_r.ltk_high;
          res_nxt.out_key_low  = rd_data_r.ltk_low;
          res_nxt.out_ediv     = rd_data_r.ediv;
          res_nxt.out_random   = rd_data_r.rnd;
          res_nxt.out_key_len  = rd_data_r.key_len;
          res_nxt.out_security = rd_data_r.security;
        end
      end
      default: ;  // undefined codes change nothing, result holds only slot and count
    endcase
    res_nxt.bond_count = btl_pkg::COUNT_W'($countones(valid_nxt));
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tgt_r] <= wr_ent;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= btl_pkg::S_IDLE;
      valid_r     <= '0;
      seq_r       <= '0;
      scan_idx_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= (state_r == btl_pkg::S_SCAN);
      if (in_fire && in_ch.action == btl_pkg::ACT_ADD) begin
        seq_r <= seq_r + btl_pkg::AGE_W'(1);
      end
      if (in_fire) begin
        scan_idx_r <= '0;
      end else if (state_r == btl_pkg::S_SCAN && !scan_last) begin
        scan_idx_r <= scan_idx_r + SW'(1);
      end
      if (advance) begin
        valid_r     <= valid_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture, scan bookkeeping, result register
  always_ff @(posedge clk) begin
    chk_idx_r <= scan_idx_r;
    if (in_fire) begin
      req_r.action         <= in_ch.action;
      req_r.slot           <= in_ch.slot;
      req_r.address_type   <= in_ch.address_type;
      req_r.device_address <= in_ch.device_address;
      req_r.key_high       <= in_ch.key_high;
      req_r.key_low        <= in_ch.key_low;
      req_r.key_present    <= in_ch.key_present;
      req_r.ediv_value     <= in_ch.ediv_value;
      req_r.random_value   <= in_ch.random_value;
      req_r.random_present <= in_ch.random_present;
      req_r.key_len        <= in_ch.key_len;
      req_r.security_flags <= in_ch.security_flags;
      hit_found_r          <= 1'b0;
      empty_found_r        <= 1'b0;
    end else if (chk_vld_r) begin
      // first matching entry
      if (!hit_found_r && valid_r[chk_idx_r] &&
          rd_data_r.atype == req_r.address_type &&
          rd_data_r.addr == req_r.device_address) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= chk_idx_r;
      end
      // first empty slot
      if (!empty_found_r && !valid_r[chk_idx_r]) begin
        empty_found_r <= 1'b1;
        empty_idx_r   <= chk_idx_r;
      end
      // oldest entry, ties stay at the lower index
      if (chk_idx_r == '0 || rd_data_r.age < lru_age_r) begin
        lru_idx_r <= chk_idx_r;
        lru_age_r <= rd_data_r.age;
      end
    end
    if (state_r == btl_pkg::S_READ) begin
      tgt_r <= tgt;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.result_slot      = res_r.result_slot;
  assign out_ch.entry_valid      = res_r.entry_valid;
  assign out_ch.out_address_type = res_r.out_address_type;
  assign out_ch.out_address      = res_r.out_address;
  assign out_ch.out_key_high     = res_r.out_key_high;
  assign out_ch.out_key_low      = res_r.out_key_low;
  assign out_ch.out_ediv         = res_r.out_ediv;
  assign out_ch.out_random       = res_r.out_random;
  assign out_ch.out_key_len      = res_r.out_key_len;
  assign out_ch.out_security     = res_r.out_security;
  assign out_ch.bond_count       = res_r.bond_count;

  // a write-back always comes with a result landing in the output register
  `BTL_ASSERT_NEXT(a_wb_gives_result, clk, rst_n, mem_we, out_valid_r)
  // the age counter moves only on an accepted add
  `BTL_ASSERT_NEXT(a_seq_only_on_add, clk, rst_n,
    !(in_fire && in_ch.action == btl_pkg::ACT_ADD), $stable(seq_r))
  // reported count agrees with the valid marks it was taken from
  `BTL_ASSERT_NEXT(a_count_matches, clk, rst_n, advance,
    res_r.bond_count == btl_pkg::COUNT_W'($countones(valid_r)))
  // memory is never written outside the write-back step
  `BTL_ASSERT_NOW(a_we_in_modify, clk, rst_n, mem_we,
    state_r == btl_pkg::S_MODIFY)

endmodule

`default_nettype wire
